// File: sv/nmea_sentence_checker_assert.svh
// Assertion macros for the sentence checker.
// NSC_ASSERT expects clk and rst_n in the scope where it is used; NSC_ASSERT_RST expects clk.
`ifndef NMEA_SENTENCE_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_ASSERT_SVH
`ifndef SYNTH
`define NSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSC_ASSERT(lbl, prop, msg)
`define NSC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: sv/nsc_pkg.sv
package nsc_pkg;

  localparam int MAX_LEN   = 128;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int HDR_LEN   = 6;
  localparam int HDR_COUNT = 5;
  localparam int POS_W     = $clog2(HDR_LEN + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef logic [2:0] sent_type_t;

  localparam sent_type_t TYPE_UNKNOWN = 3'd0;
  localparam sent_type_t TYPE_GPGGA   = 3'd1;
  localparam sent_type_t TYPE_GPGSA   = 3'd2;
  localparam sent_type_t TYPE_GPGSV   = 3'd3;
  localparam sent_type_t TYPE_GPRMC   = 3'd4;
  localparam sent_type_t TYPE_GPVTG   = 3'd5;

  localparam sent_type_t HDR_TYPE [HDR_COUNT] = '{
    TYPE_GPGGA, TYPE_GPGSA, TYPE_GPGSV, TYPE_GPRMC, TYPE_GPVTG
  };

  localparam logic [7:0] HDR_TEXT [HDR_COUNT][HDR_LEN] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},  // $GPGGA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // $GPGSA
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56},  // $GPGSV
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},  // $GPRMC
    '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}   // $GPVTG
  };

  typedef struct packed {
    logic en;   // text byte to feed the matcher
    logic clr;  // sentence closed, return to reset state
  } hdr_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  function automatic hex_dig_t hex_digit(input logic [7:0] c);
    hex_dig_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.val = 4'(c - 8'h37);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: sv/nsc_if.sv
interface nsc_in_if;
  import nsc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink (input valid, input char_byte, input last_byte, output ready);
endinterface

interface nsc_out_if;
  import nsc_pkg::*;

  logic       valid;
  logic       ready;
  logic       sentence_ok;
  sent_type_t sentence_type;
  logic [7:0] computed_sum;
  logic [15:0] received_sum;
  logic       star_found;

  modport source (output valid, output sentence_ok, output sentence_type,
                  output computed_sum, output received_sum, output star_found,
                  input ready);
  modport sink (input valid, input sentence_ok, input sentence_type,
                input computed_sum, input received_sum, input star_found,
                output ready);
endinterface

// File: sv/nsc_hdr_match.sv
module nsc_hdr_match (
  input  logic             clk,
  input  logic             rst_n,
  input  nsc_pkg::hdr_ctl_t ctl,
  input  logic [7:0]       char_byte,
  output nsc_pkg::sent_type_t type_nxt
);
  import nsc_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_FIELD = 3'b010,
    PH_DONE  = 3'b100
  } hdr_phase_t;

  hdr_phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [HDR_COUNT-1:0] cand_r, cand_nxt;
  logic                 is_comma;
  logic                 match_en;

  assign is_comma = (char_byte == CH_COMMA);

  always_comb begin
    phase_nxt = phase_r;
    match_en  = 1'b0;
    if (ctl.en) begin
      unique case (phase_r)
        PH_SKIP: begin
          if (!is_comma) begin
            phase_nxt = PH_FIELD;
            match_en  = 1'b1;
          end
        end
        PH_FIELD: begin
          if (is_comma) begin
            phase_nxt = PH_DONE;
          end else begin
            match_en = 1'b1;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    cand_nxt = cand_r;
    if (match_en) begin
      if (pos_r < POS_W'(HDR_LEN)) begin
        for (int k = 0; k < HDR_COUNT; k++) begin
          if (HDR_TEXT[k][pos_r] != char_byte) cand_nxt[k] = 1'b0;
        end
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        // field longer than any header
        cand_nxt = '0;
      end
    end
  end

  // lowest surviving candidate wins
  always_comb begin
    type_nxt = TYPE_UNKNOWN;
    if (phase_nxt != PH_SKIP && pos_nxt == POS_W'(HDR_LEN)) begin
      for (int k = HDR_COUNT - 1; k >= 0; k--) begin
        if (cand_nxt[k]) type_nxt = HDR_TYPE[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      phase_r <= PH_SKIP;
      pos_r   <= '0;
      cand_r  <= '1;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

// File: sv/nmea_sentence_checker.sv
// The result beat is registered when the last byte is accepted.
// Throughput: one byte per cycle; input stalls while a result waits untaken.
// Per-byte work is one XOR, one hex shift and one header compare per cycle.
// Reset: synchronous, active low; clears sentence state and the result valid.
// Sentence state also returns to its reset values after each last byte.
`include "nmea_sentence_checker_assert.svh"

module nmea_sentence_checker (
  input logic       clk,
  input logic       rst_n,
  nsc_in_if.sink    in_ch,
  nsc_out_if.source out_ch
);
  import nsc_pkg::*;

  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             text_ended_r, text_ended_nxt;
  logic             dollar_r, dollar_nxt;
  logic             star_r, star_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [15:0]      hex_r, hex_nxt;
  logic             hex_run_r, hex_run_nxt;

  logic             out_valid_r;
  logic             ok_r;
  sent_type_t       type_r;
  logic [7:0]       comp_r;
  logic [15:0]      recv_r;
  logic             found_r;

  logic             in_acc;
  logic             in_room;
  logic             in_text;
  logic             text_en;
  logic             close;
  hex_dig_t         hd;
  hdr_ctl_t         hdr_ctl;
  sent_type_t       hdr_type;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign close       = in_acc && in_ch.last_byte;
  assign in_room     = (byte_cnt_r < CNT_W'(MAX_LEN));
  assign in_text     = in_room && !text_ended_r;
  assign text_en     = in_acc && in_text && (in_ch.char_byte != CH_NUL);
  assign hd          = hex_digit(in_ch.char_byte);

  assign hdr_ctl.en  = text_en;
  assign hdr_ctl.clr = close;

  nsc_hdr_match u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hdr_ctl),
    .char_byte (in_ch.char_byte),
    .type_nxt  (hdr_type)
  );

  always_comb begin
    byte_cnt_nxt   = byte_cnt_r;
    text_ended_nxt = text_ended_r;
    dollar_nxt     = dollar_r;
    star_nxt       = star_r;
    xor_nxt        = xor_r;
    hex_nxt        = hex_r;
    hex_run_nxt    = hex_run_r;
    if (in_acc && in_room) byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
    if (in_acc && in_text && in_ch.char_byte == CH_NUL) text_ended_nxt = 1'b1;
    if (text_en) begin
      if (!star_r) begin
        priority if (in_ch.char_byte == CH_STAR) begin
          star_nxt    = 1'b1;
          hex_run_nxt = 1'b1;
        end else if (dollar_r) begin
          xor_nxt = xor_r ^ in_ch.char_byte;
        end else if (in_ch.char_byte == CH_DOLLAR) begin
          dollar_nxt = 1'b1;
        end else begin
          dollar_nxt = dollar_r;
        end
      end else if (hex_run_r) begin
        if (!hd.ok) begin
          hex_run_nxt = 1'b0;
        end else begin
          hex_nxt = {hex_r[11:0], hd.val};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || close) begin
      byte_cnt_r   <= '0;
      text_ended_r <= 1'b0;
      dollar_r     <= 1'b0;
      star_r       <= 1'b0;
      xor_r        <= '0;
      hex_r        <= '0;
      hex_run_r    <= 1'b0;
    end else begin
      byte_cnt_r   <= byte_cnt_nxt;
      text_ended_r <= text_ended_nxt;
      dollar_r     <= dollar_nxt;
      star_r       <= star_nxt;
      xor_r        <= xor_nxt;
      hex_r        <= hex_nxt;
      hex_run_r    <= hex_run_nxt;
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (close) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      ok_r    <= star_nxt && ({8'h00, xor_nxt} == hex_nxt);
      type_r  <= hdr_type;
      comp_r  <= star_nxt ? xor_nxt : 8'h00;
      recv_r  <= star_nxt ? hex_nxt : 16'h0000;
      found_r <= star_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sentence_ok   = ok_r;
  assign out_ch.sentence_type = type_r;
  assign out_ch.computed_sum  = comp_r;
  assign out_ch.received_sum  = recv_r;
  assign out_ch.star_found    = found_r;

  `NSC_ASSERT_RST(a_rst_no_result, !rst_n |=> !out_valid_r, "result valid after reset")
  `NSC_ASSERT(a_result_from_last, $rose(out_valid_r) |-> $past(close), "result without last byte")
  `NSC_ASSERT(a_ok_needs_star, out_valid_r |-> (!ok_r || found_r), "ok without star")
  `NSC_ASSERT(a_no_star_zero, (out_valid_r && !found_r) |-> (comp_r == '0 && recv_r == '0), "sums not zero without star")
  `NSC_ASSERT(a_clear_on_last, close |=> (byte_cnt_r == '0 && !star_r && !dollar_r), "state not cleared after last byte")
  `NSC_ASSERT(a_cnt_bound, byte_cnt_r <= CNT_W'(MAX_LEN), "byte count past limit")

endmodule

// File: tb/nmea_sentence_checker_tb.sv
`timescale 1ns / 100ps

module nmea_sentence_checker_tb;
  import nsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] octet_t;
  typedef octet_t octet_q_t[$];

  typedef enum logic [1:0] {HDR_LEAD, HDR_FIELD, HDR_CLOSED} hdr_phase_e;

  typedef struct {
    logic        ok;
    sent_type_t  kind;
    logic [7:0]  calc;
    logic [15:0] rcvd;
    logic        star;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();

  nmea_sentence_checker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  verdict_t pending_verdicts[$];

  // sentence tracker state
  int unsigned              seen_count;
  bit                       text_done;
  bit                       got_dollar;
  bit                       got_star;
  bit                       in_hex;
  logic [7:0]               run_xor;
  logic [15:0]              hex_acc;
  logic [HDR_COUNT-1:0]     hdr_alive;
  int                       hdr_idx;
  hdr_phase_e               hdr_state;

  function automatic void clear_tracker();
    seen_count = 0;
    text_done  = 1'b0;
    got_dollar = 1'b0;
    got_star   = 1'b0;
    in_hex     = 1'b0;
    run_xor    = '0;
    hex_acc    = '0;
    hdr_alive  = '1;
    hdr_idx    = 0;
    hdr_state  = HDR_LEAD;
  endfunction

  function automatic int hex_nibble(input octet_t c);
    if (c >= "0" && c <= "9") return c - 8'h30;
    if (c >= "a" && c <= "f") return c - 8'h57;
    if (c >= "A" && c <= "F") return c - 8'h37;
    return -1;
  endfunction

  function automatic void match_header(input octet_t c);
    if (hdr_state == HDR_LEAD) begin
      if (c == CH_COMMA) return;
      hdr_state = HDR_FIELD;
    end else if (hdr_state == HDR_FIELD) begin
      if (c == CH_COMMA) begin
        hdr_state = HDR_CLOSED;
        return;
      end
    end else begin
      return;
    end
    if (hdr_idx < HDR_LEN) begin
      for (int k = 0; k < HDR_COUNT; k++) begin
        if (HDR_TEXT[k][hdr_idx] != c) hdr_alive[k] = 1'b0;
      end
      hdr_idx++;
    end else begin
      // field too long: no header can match
      hdr_alive = '0;
    end
  endfunction

  task automatic track_sentence_byte(input octet_t c, input bit fin);
    int nib;
    sent_type_t kind;
    verdict_t v;
    if (seen_count < MAX_LEN) begin
      if (!text_done) begin
        if (c == CH_NUL) begin
          text_done = 1'b1;
        end else begin
          if (!got_star) begin
            if (c == CH_STAR) begin
              got_star = 1'b1;
              in_hex   = 1'b1;
            end else if (got_dollar) begin
              run_xor ^= c;
            end else if (c == CH_DOLLAR) begin
              got_dollar = 1'b1;
            end
          end else if (in_hex) begin
            nib = hex_nibble(c);
            if (nib < 0) in_hex = 1'b0;
            else hex_acc = {hex_acc[11:0], 4'(nib)};
          end
          match_header(c);
        end
      end
      seen_count++;
    end
    if (!fin) return;
    kind = TYPE_UNKNOWN;
    if (hdr_state != HDR_LEAD && hdr_idx == HDR_LEN) begin
      // lowest surviving header wins
      for (int k = HDR_COUNT - 1; k >= 0; k--) begin
        if (hdr_alive[k]) kind = HDR_TYPE[k];
      end
    end
    v.ok   = got_star && ({8'h00, run_xor} == hex_acc);
    v.kind = kind;
    v.calc = got_star ? run_xor : 8'h00;
    v.rcvd = got_star ? hex_acc : 16'h0000;
    v.star = got_star;
    pending_verdicts.push_back(v);
    clear_tracker();
  endtask

  task automatic push_byte(input octet_t c, input bit fin);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.last_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_sentence_byte(c, fin);
    bytes_sent++;
  endtask

  task automatic send_sentence(input octet_q_t q);
    foreach (q[i]) push_byte(q[i], i == q.size() - 1);
  endtask

  function automatic octet_t hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 10) return 8'h30 + nib;
    return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic octet_t field_char();
    octet_t c;
    do c = octet_t'($urandom_range(8'h20, 8'h7E)); while (c == CH_STAR);
    return c;
  endfunction

  function automatic void put_text(ref octet_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // '$' + payload + '*' + two checksum digits, optionally spoilt
  function automatic void put_nmea(ref octet_q_t q, input string payload,
                                   input bit corrupt, input bit lower);
    octet_t sum;
    sum = 8'h00;
    q.push_back(CH_DOLLAR);
    for (int i = 0; i < payload.len(); i++) begin
      q.push_back(payload[i]);
      sum ^= payload[i];
    end
    if (corrupt) sum ^= 8'h10;
    q.push_back(CH_STAR);
    q.push_back(hex_char(sum[7:4], lower));
    q.push_back(hex_char(sum[3:0], lower));
  endfunction

  function automatic void build_wellformed(ref octet_q_t q);
    octet_t     body[$];
    octet_t     sum;
    logic [23:0] tx;
    int         hdr;
    int         digits;
    sum = 8'h00;
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 2)) q.push_back(CH_COMMA);
    if ($urandom_range(4) != 0) begin
      hdr = $urandom_range(HDR_COUNT - 1);
      for (int j = 1; j < HDR_LEN; j++) body.push_back(HDR_TEXT[hdr][j]);
    end else begin
      repeat ($urandom_range(2, 7)) body.push_back(octet_t'($urandom_range(8'h41, 8'h5A)));
    end
    repeat ($urandom_range(0, 4)) begin
      body.push_back(CH_COMMA);
      repeat ($urandom_range(0, 6)) body.push_back(field_char());
    end
    // now and then run well past the length limit
    if ($urandom_range(39) == 0) begin
      body.push_back(CH_COMMA);
      repeat ($urandom_range(110, 150)) body.push_back(field_char());
    end
    foreach (body[i]) sum ^= body[i];
    tx = {16'h0000, sum};
    digits = 2;
    case ($urandom_range(9))
      7: tx[7:0] = sum ^ octet_t'($urandom_range(1, 255));
      8: begin
        tx = 24'($urandom);
        digits = $urandom_range(3, 6);
      end
      9: digits = $urandom_range(0, 1);
      default: ;
    endcase
    q.push_back(CH_DOLLAR);
    q = {q, body};
    q.push_back(CH_STAR);
    for (int d = digits - 1; d >= 0; d--) q.push_back(hex_char(tx[4*d +: 4], $urandom_range(1)));
    if ($urandom_range(2) == 0) begin
      q.push_back(8'h0D);
      q.push_back(8'h0A);
    end
  endfunction

  function automatic void build_random_sentence(ref octet_q_t q);
    int pick;
    int pos;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 12)) q.push_back(octet_t'($urandom_range(255)));
      return;
    end
    build_wellformed(q);
    if (pick < 35) begin
      pos = $urandom_range(q.size() - 1);
      case ($urandom_range(2))
        0: q[pos] = octet_t'($urandom_range(255));
        1: if (q.size() > 1) q.delete(pos);
        default: q.insert(pos, CH_NUL);
      endcase
    end
  endfunction

  task automatic check_talker_headers();
    string    names[HDR_COUNT] = '{"GPGGA", "GPGSA", "GPGSV", "GPRMC", "GPVTG"};
    octet_q_t q;
    for (int h = 0; h < HDR_COUNT; h++) begin
      q.delete();
      put_nmea(q, {names[h], ",0,A"}, 1'b0, h[0]);
      send_sentence(q);
    end
    q.delete();
    put_nmea(q, "GPGGA,1", 1'b1, 1'b0);
    send_sentence(q);
  endtask

  task automatic check_checksum_digits();
    string    cases[9] = '{"$J*4a", "$J*4A", "$A*FFFF0041", "$A*4G1", "$A*",
                           "$A*0x41", "$A* 41", "$A*41*7", "$*00"};
    octet_q_t q;
    foreach (cases[i]) begin
      q.delete();
      put_text(q, cases[i]);
      send_sentence(q);
    end
  endtask

  task automatic check_special_cases();
    string    cases[6] = '{"GPGGA*00", "$GPRMC,1,2", "$GPVTG", ",,,,",
                           "$GPGG,1*00", "$GPGGAA,1*00"};
    octet_t   lone[3] = '{8'h00, 8'hFF, 8'h80};
    octet_q_t q;
    foreach (cases[i]) begin
      q.delete();
      put_text(q, cases[i]);
      send_sentence(q);
    end
    q.delete();
    put_text(q, ",,");
    put_nmea(q, "GPGSV,9", 1'b0, 1'b0);
    send_sentence(q);
    q.delete();
    put_nmea(q, "A$B", 1'b0, 1'b1);
    send_sentence(q);
    // zero byte ends the text before the star
    q.delete();
    put_text(q, "$GPGSA,1");
    q.push_back(CH_NUL);
    put_text(q, "*00");
    send_sentence(q);
    q.delete();
    put_text(q, "$");
    q.push_back(8'hFF);
    q.push_back(8'h80);
    put_text(q, "*7F");
    send_sentence(q);
    foreach (lone[i]) begin
      q.delete();
      q.push_back(lone[i]);
      send_sentence(q);
    end
  endtask

  task automatic check_length_limit();
    octet_q_t q;
    // checksum digits straddle the limit
    put_text(q, "$GPGGA,");
    repeat (118) q.push_back(8'h42);
    put_text(q, "*123456");
    send_sentence(q);
  endtask

  task automatic check_random_traffic();
    int       gaps[4]   = '{0, 52, 0, 12};
    int       stalls[4] = '{0, 0, 52, 12};
    int       byte_mark;
    octet_q_t q;
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      byte_mark = bytes_sent;
      while (bytes_sent - byte_mark < 16) begin
        q.delete();
        build_random_sentence(q);
        send_sentence(q);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no sentence outstanding");
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("sentence_ok", 16'(want.ok), 16'(out_ch.sentence_ok));
        compare_field("sentence_type", 16'(want.kind), 16'(out_ch.sentence_type));
        compare_field("computed_sum", 16'(want.calc), 16'(out_ch.computed_sum));
        compare_field("received_sum", want.rcvd, out_ch.received_sum);
        compare_field("star_found", 16'(want.star), 16'(out_ch.star_found));
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nmea_sentence_checker regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    clear_tracker();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    check_talker_headers();
    check_checksum_digits();
    check_special_cases();
    check_length_limit();
    check_random_traffic();

    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // drain: allow for the result register
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("nmea_sentence_checker regression: pass");
    end else begin
      $display("nmea_sentence_checker regression: fail");
    end
    $finish;
  end

endmodule
